// ===== rtl/core/ils_pkg.sv =====
// Shared types, character codes and the character classifier for the literal summer.
`timescale 1ns / 1ps

package ils_pkg;

    localparam int TQ_DEPTH = 4;
    localparam int TQ_AW    = $clog2(TQ_DEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] number_value;
        logic signed [63:0] running_total;
        logic               is_final;
    } out_item_t;

    // Classified character as handed from the front end to the scanner
    typedef struct packed {
        logic       eoi;
        logic       minus;
        logic       quote;
        logic       bin_dig;
        logic       oct_dig;
        logic       dec_dig;
        logic       hex_dig;
        logic       is_b;
        logic       is_x;
        logic [3:0] dval;
    } tok_t;

    typedef enum logic [7:0] {
        MODE_IDLE  = 8'b0000_0001,
        MODE_MINUS = 8'b0000_0010,
        MODE_QUOTE = 8'b0000_0100,
        MODE_ZERO  = 8'b0000_1000,
        MODE_BIN   = 8'b0001_0000,
        MODE_HEX   = 8'b0010_0000,
        MODE_OCT   = 8'b0100_0000,
        MODE_DEC   = 8'b1000_0000
    } mode_t;

    function automatic tok_t classify(input logic [7:0] c);
        tok_t t;
        t         = '0;
        t.minus   = (c == CH_MINUS);
        t.quote   = (c == CH_DQUOTE);
        t.is_b    = (c == CH_LO_B) || (c == CH_UP_B);
        t.is_x    = (c == CH_LO_X) || (c == CH_UP_X);
        t.dec_dig = (c >= CH_ZERO) && (c <= CH_NINE);
        t.oct_dig = (c >= CH_ZERO) && (c <= CH_SEVEN);
        t.bin_dig = (c == CH_ZERO) || (c == CH_ONE);
        if (t.dec_dig) begin
            t.hex_dig = 1'b1;
            t.dval    = 4'(c - CH_ZERO);
        end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
            t.hex_dig = 1'b1;
            t.dval    = 4'(c - CH_LO_A + 8'd10);
        end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            t.hex_dig = 1'b1;
            t.dval    = 4'(c - CH_UP_A + 8'd10);
        end
        return t;
    endfunction

endpackage

// ===== rtl/core/ils_front.sv =====
// Front end: takes characters, drops escapes, classifies and queues tokens.
`timescale 1ns / 1ps

module ils_front
    import ils_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     tok_valid,
    input  logic     tok_ready,
    output tok_t     tok
);

    tok_t                tq_mem [TQ_DEPTH];
    logic [TQ_AW-1:0]    tq_wr_reg, tq_wr_next;
    logic [TQ_AW-1:0]    tq_rd_reg, tq_rd_next;
    logic [TQ_AW:0]      tq_cnt_reg, tq_cnt_next;
    logic                skip_reg, skip_next;
    logic                accept;
    logic                push;
    logic                pop;
    tok_t                push_tok;

    assign s_ready   = (tq_cnt_reg != (TQ_AW+1)'(TQ_DEPTH));
    assign accept    = s_valid && s_ready;
    assign tok_valid = (tq_cnt_reg != '0);
    assign tok       = tq_mem[tq_rd_reg];
    assign pop       = tok_valid && tok_ready;

    always_comb begin
        skip_next = skip_reg;
        push      = 1'b0;
        push_tok  = classify(s_data.char_code);
        if (accept) begin
            if (s_data.end_of_input) begin
                push         = 1'b1;
                push_tok     = '0;
                push_tok.eoi = 1'b1;
                skip_next    = 1'b0;
            end else if (skip_reg) begin
                skip_next = 1'b0;
            end else if (s_data.char_code == CH_BSLASH) begin
                // backslash swallows itself and the next character
                skip_next = 1'b1;
            end else begin
                push = 1'b1;
            end
        end
        tq_wr_next  = push ? tq_wr_reg + 1'b1 : tq_wr_reg;
        tq_rd_next  = pop ? tq_rd_reg + 1'b1 : tq_rd_reg;
        tq_cnt_next = tq_cnt_reg + (TQ_AW+1)'(push) - (TQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            tq_mem[tq_wr_reg] <= push_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tq_wr_reg  <= '0;
            tq_rd_reg  <= '0;
            tq_cnt_reg <= '0;
            skip_reg   <= 1'b0;
        end else begin
            tq_wr_reg  <= tq_wr_next;
            tq_rd_reg  <= tq_rd_next;
            tq_cnt_reg <= tq_cnt_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

// ===== rtl/core/ils_back.sv =====
// Back end: literal scanner, running total and result queue.
`timescale 1ns / 1ps

module ils_back
    import ils_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic      cfg_report,
    input  logic      tok_valid,
    output logic      tok_ready,
    input  tok_t      tok,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    mode_t            mode_reg, mode_next;
    logic             neg_reg, neg_next;
    logic [63:0]      lit_reg, lit_next;
    logic [63:0]      sum_reg, sum_next;
    logic             report_reg;

    out_item_t        oq_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_wr_next;
    logic [OQ_AW-1:0] oq_rd_reg, oq_rd_next;
    logic [OQ_AW:0]   oq_cnt_reg, oq_cnt_next;

    logic             take;
    logic             pop;
    logic             do_finish;
    logic             do_start;
    logic             start_neg;
    logic             digit_ok;
    logic [63:0]      acc;
    logic [63:0]      add_val;
    logic [63:0]      sum_fin;
    logic             rep_fire;
    logic [1:0]       push_n;
    out_item_t        res_a;
    out_item_t        res_b;
    out_item_t        rep_item;
    out_item_t        fin_item;

    // two free slots so an end of stream with a pending report never stalls mid-item
    assign tok_ready = (oq_cnt_reg <= (OQ_AW+1)'(OQ_DEPTH - 2));
    assign take      = tok_valid && tok_ready;
    assign m_valid   = (oq_cnt_reg != '0);
    assign m_data    = oq_mem[oq_rd_reg];
    assign pop       = m_valid && m_ready;

    // closing a literal: one add or subtract into the total
    assign add_val  = neg_reg ? (64'd0 - lit_reg) : lit_reg;
    assign sum_fin  = neg_reg ? (sum_reg - lit_reg) : (sum_reg + lit_reg);

    always_comb begin
        case (mode_reg)
            MODE_BIN: begin
                digit_ok = tok.bin_dig;
                acc      = {lit_reg[62:0], 1'b0};
            end
            MODE_OCT: begin
                digit_ok = tok.oct_dig;
                acc      = {lit_reg[60:0], 3'b000};
            end
            MODE_DEC: begin
                digit_ok = tok.dec_dig;
                acc      = {lit_reg[60:0], 3'b000} + {lit_reg[62:0], 1'b0};
            end
            MODE_HEX: begin
                digit_ok = tok.hex_dig;
                acc      = {lit_reg[59:0], 4'b0000};
            end
            default: begin
                digit_ok = 1'b0;
                acc      = lit_reg;
            end
        endcase
    end

    always_comb begin
        mode_next = mode_reg;
        neg_next  = neg_reg;
        lit_next  = lit_reg;
        sum_next  = sum_reg;
        do_finish = 1'b0;
        do_start  = 1'b0;
        start_neg = 1'b0;

        if (tok.eoi) begin
            do_finish = mode_reg inside {MODE_ZERO, MODE_BIN, MODE_HEX, MODE_OCT, MODE_DEC};
        end else begin
            case (mode_reg)
                MODE_MINUS: begin
                    if (!tok.minus) begin
                        do_start  = 1'b1;
                        start_neg = 1'b1;
                    end
                end
                MODE_QUOTE: begin
                    if (tok.quote) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_ZERO: begin
                    // lone zero eats the following character
                    if (tok.is_b) begin
                        mode_next = MODE_BIN;
                    end else if (tok.is_x) begin
                        mode_next = MODE_HEX;
                    end else if (tok.oct_dig) begin
                        mode_next = MODE_OCT;
                        lit_next  = 64'(tok.dval);
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                MODE_BIN, MODE_OCT, MODE_DEC, MODE_HEX: begin
                    if (digit_ok) begin
                        lit_next = acc + 64'(tok.dval);
                    end else begin
                        do_finish = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
        end

        if (do_finish) begin
            sum_next  = sum_fin;
            mode_next = MODE_IDLE;
            neg_next  = 1'b0;
            lit_next  = '0;
        end

        if (do_start) begin
            neg_next = 1'b0;
            lit_next = '0;
            if (tok.minus) begin
                mode_next = MODE_MINUS;
                neg_next  = 1'b1;
            end else if (tok.quote) begin
                mode_next = MODE_QUOTE;
            end else if (tok.dec_dig && (tok.dval == 4'd0)) begin
                mode_next = MODE_ZERO;
                neg_next  = start_neg;
            end else if (tok.dec_dig) begin
                mode_next = MODE_DEC;
                neg_next  = start_neg;
                lit_next  = 64'(tok.dval);
            end else begin
                mode_next = MODE_IDLE;
            end
        end

        if (tok.eoi) begin
            mode_next = MODE_IDLE;
            neg_next  = 1'b0;
            lit_next  = '0;
            sum_next  = '0;
        end
    end

    always_comb begin
        rep_item.number_value  = add_val;
        rep_item.running_total = sum_fin;
        rep_item.is_final      = 1'b0;
        fin_item.number_value  = '0;
        fin_item.running_total = do_finish ? sum_fin : sum_reg;
        fin_item.is_final      = 1'b1;

        rep_fire = do_finish && report_reg && (lit_reg != '0);
        res_a    = rep_item;
        res_b    = fin_item;
        push_n   = 2'd0;
        if (take) begin
            if (rep_fire) begin
                push_n = tok.eoi ? 2'd2 : 2'd1;
            end else if (tok.eoi) begin
                res_a  = fin_item;
                push_n = 2'd1;
            end
        end

        oq_wr_next  = oq_wr_reg + OQ_AW'(push_n);
        oq_rd_next  = pop ? oq_rd_reg + 1'b1 : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + (OQ_AW+1)'(push_n) - (OQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            oq_mem[oq_wr_reg] <= res_a;
        end
        if (push_n == 2'd2) begin
            oq_mem[oq_wr_reg + 1'b1] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            neg_reg    <= 1'b0;
            lit_reg    <= '0;
            sum_reg    <= '0;
            report_reg <= 1'b0;
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end else begin
            if (take) begin
                mode_reg <= mode_next;
                neg_reg  <= neg_next;
                lit_reg  <= lit_next;
                sum_reg  <= sum_next;
            end
            if (cfg_we) begin
                report_reg <= cfg_report;
            end
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

endmodule

// ===== rtl/core/integer_literal_summer.sv =====
// Top level of the integer literal summer: front end, back end and config register port.
//
// Use: characters enter on the s_ channel (s_valid/s_ready, s_data holds char_code and
// end_of_input). Every integer literal in the stream (binary, octal, decimal, hex, with an
// optional run of minus signs, outside quotes and escapes) is added to a 64-bit total.
// Results leave on the m_ channel: with report_each_number set, one result per completed
// nonzero literal; on end_of_input a final result carrying the total, after which the
// total restarts from zero. An end of stream may give two results in a row.
// Config: cfg_valid/cfg_data write report_each_number; cfg_ready is always high.
// Write it only while the block is idle.
// Throughput: one character per cycle unless m_ stalls. A four-entry token queue sits
// between the classifier and the scanner, and a four-entry result queue drives m_.
// The character that closes a literal is registered in the token queue; when the scanner
// takes it, the result is registered in the result queue and presented on m_.
// Receiver stall: results wait in the result queue; once it cannot take two more, the
// scanner holds and the token queue fills, then s_ready drops.
// Reset (aresetn low, synchronous): queues emptied, scanner idle, total and register zero.
`timescale 1ns / 1ps

module integer_literal_summer
    import ils_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic tok_valid;
    logic tok_ready;
    tok_t tok;
    logic cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ils_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    ils_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_report (cfg_data),
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .tok        (tok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// ===== rtl/core/ils_checker.sv =====
// Port-level checks for the integer literal summer, bound to the top level.
`timescale 1ns / 1ps

module ils_checker
    import ils_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // offered character must hold until its transfer
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed or dropped while waiting");

    // result must hold while the receiver stalls
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped during stall");

    a_final_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_final |-> m_data.number_value == 64'sd0)
        else $error("final result carries a number value");

    a_report_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.is_final |-> m_data.number_value != 64'sd0)
        else $error("zero-valued number reported");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result presented straight after reset");

endmodule

bind integer_literal_summer ils_checker u_ils_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
